FILE: hw/rtl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants, types and the CORDIC angle table for euler_to_quaternion.
// ----------------------------------------------------------------------------
`default_nettype none

package e2q_pkg;

    localparam int ANGLE_FRAC_BITS = 7;
    localparam int OUT_FRAC_BITS   = 15;
    localparam int CORDIC_STAGES   = 16;

    localparam int IN_W    = 17;
    localparam int OUT_W   = 16;
    localparam int QF      = 30;
    localparam int CW      = 34;
    localparam int PW      = 32;
    localparam int STAGE_W = $clog2(CORDIC_STAGES);

    localparam longint PI_Q30       = 64'd3373259426;
    localparam longint INV_GAIN_Q30 = 64'd652032874;
    localparam longint HALF_PI_Q30  = (PI_Q30 + 1) / 2;

    localparam int QUARTER = 180 << ANGLE_FRAC_BITS;
    localparam int PERIOD  = 4 * QUARTER;
    localparam int DENOM   = 360 << ANGLE_FRAC_BITS;
    localparam int RW      = $clog2(PERIOD) + 2;
    localparam int MAG_W   = $clog2(QUARTER + 1);

    localparam longint QUOT      = PI_Q30 / DENOM;
    localparam longint REM       = PI_Q30 % DENOM;
    localparam int     DEN_SHIFT = ANGLE_FRAC_BITS + 3;
    localparam int     RECIP_SH  = 32;
    localparam longint RECIP     = ((64'd1 << RECIP_SH) + 44) / 45;

    localparam int LATENCY = 3 + CORDIC_STAGES + 3;

    localparam logic signed [CW-1:0] ATAN [32] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
        34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
        34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
        34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
        34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
        34'sd1023,      34'sd511,       34'sd255,       34'sd127,
        34'sd63,        34'sd31,        34'sd15,        34'sd7,
        34'sd3,         34'sd1,         34'sd0,         34'sd0
    };

    typedef struct packed {
        logic                 valid;
        logic                 flip;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cell_t;

endpackage

`default_nettype wire

FILE: hw/rtl/euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Euler angles to unit quaternion in Q1.15 through pipelined CORDIC rows.
//
//   channel  | ports                         | transfer
//   ---------+-------------------------------+----------------------------
//   command  | start, angle_x/y/z, busy      | edge with start && !busy
//   result   | done, quat_w/x/y/z            | edge ending the done cycle
//
// One transfer in every cycle; busy stays low.
// Items pass through the reduction stages, one cell per CORDIC stage and the products.
// Reset clears only the valid bits; a reset drops items in flight.
// The receiver cannot stall; each result shows for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_to_quaternion
    import e2q_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic signed [IN_W-1:0]  angle_x,
    input  wire logic signed [IN_W-1:0]  angle_y,
    input  wire logic signed [IN_W-1:0]  angle_z,
    output logic                         done,
    output logic signed [OUT_W-1:0]      quat_w,
    output logic signed [OUT_W-1:0]      quat_x,
    output logic signed [OUT_W-1:0]      quat_y,
    output logic signed [OUT_W-1:0]      quat_z
);

    logic                   accept;
    logic signed [IN_W-1:0] angles [3];
    cell_t                  chain [3][CORDIC_STAGES+1];

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign angles[0] = angle_x;
    assign angles[1] = angle_y;
    assign angles[2] = angle_z;

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        e2q_prep u_prep (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (accept),
            .angle    (angles[a]),
            .out_cell (chain[a][0])
        );
        for (genvar s = 0; s < CORDIC_STAGES; s++)
        begin : g_cell
            e2q_cordic_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .stage    (STAGE_W'(s)),
                .atan     (ATAN[s]),
                .in_cell  (chain[a][s]),
                .out_cell (chain[a][s+1])
            );
        end
    end

    e2q_quat u_quat (
        .clk    (clk),
        .rst_n  (rst_n),
        .cell_x (chain[0][CORDIC_STAGES]),
        .cell_y (chain[1][CORDIC_STAGES]),
        .cell_z (chain[2][CORDIC_STAGES]),
        .done   (done),
        .quat_w (quat_w),
        .quat_x (quat_x),
        .quat_y (quat_y),
        .quat_z (quat_z)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("result missing after transfer");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without transfer");

endmodule

`default_nettype wire

FILE: hw/rtl/e2q_prep.sv
// ----------------------------------------------------------------------------
// e2q_prep
// Half-angle reduction and degree-to-radian scaling, three pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_prep
    import e2q_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic signed [IN_W-1:0] angle,
    output cell_t                       out_cell
);

    localparam int P1_W = MAG_W + 18;
    localparam int N_W  = MAG_W + 17;
    localparam int V_W  = N_W - DEN_SHIFT;
    localparam int Q_W  = V_W + 28;

    logic signed [RW-1:0]  a_ext;
    logic signed [RW-1:0]  r0;
    logic signed [RW-1:0]  r1;
    logic signed [RW-1:0]  r_abs;
    logic                  flip1;

    logic                  v1_reg;
    logic                  neg1_reg;
    logic                  flip1_reg;
    logic [MAG_W-1:0]      mag_reg;

    logic [N_W-1:0]        n2;
    logic                  v2_reg;
    logic                  neg2_reg;
    logic                  flip2_reg;
    logic [P1_W-1:0]       p1_reg;
    logic [V_W-1:0]        v_reg;

    logic [Q_W-1:0]        q3;
    logic signed [CW-1:0]  zmag3;
    cell_t                 cell_next;
    cell_t                 cell_reg;

    always_comb
    begin
        a_ext = RW'(angle);
        r0    = (a_ext < 0) ? a_ext + RW'(PERIOD) : a_ext;
        flip1 = 1'b0;
        if (r0 > RW'(QUARTER) && r0 <= RW'(3 * QUARTER))
        begin
            r1    = r0 - RW'(2 * QUARTER);
            flip1 = 1'b1;
        end
        else if (r0 > RW'(3 * QUARTER))
        begin
            r1 = r0 - RW'(PERIOD);
        end
        else
        begin
            r1 = r0;
        end
        r_abs = (r1 < 0) ? -r1 : r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        neg1_reg  <= r1 < 0;
        flip1_reg <= flip1;
        mag_reg   <= r_abs[MAG_W-1:0];
    end

    // split the scale into an integer quotient and a remainder term
    assign n2 = N_W'(mag_reg) * N_W'(REM) + N_W'(DENOM / 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        neg2_reg  <= neg1_reg;
        flip2_reg <= flip1_reg;
        p1_reg    <= P1_W'(mag_reg) * P1_W'(QUOT);
        v_reg     <= n2[N_W-1:DEN_SHIFT];
    end

    // divide by 45 through a reciprocal
    assign q3    = Q_W'(v_reg) * Q_W'(RECIP);
    assign zmag3 = CW'(p1_reg) + CW'(q3[Q_W-1:RECIP_SH]);

    always_comb
    begin
        cell_next.valid = v2_reg;
        cell_next.flip  = flip2_reg;
        cell_next.x     = CW'(INV_GAIN_Q30);
        cell_next.y     = '0;
        cell_next.z     = neg2_reg ? -zmag3 : zmag3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg.valid <= 1'b0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign out_cell = cell_reg;

    a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
        cell_reg.valid |-> (cell_reg.z <= CW'(HALF_PI_Q30) && cell_reg.z >= -CW'(HALF_PI_Q30)))
        else $error("reduced angle out of range");

endmodule

`default_nettype wire

FILE: hw/rtl/e2q_cordic_cell.sv
// ----------------------------------------------------------------------------
// e2q_cordic_cell
// One rotation-mode CORDIC micro-rotation, registered toward the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_cordic_cell
    import e2q_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [STAGE_W-1:0]   stage,
    input  wire logic signed [CW-1:0] atan,
    input  wire cell_t                in_cell,
    output cell_t                     out_cell
);

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    cell_t                cell_next;
    cell_t                cell_reg;

    assign dx = in_cell.y >>> stage;
    assign dy = in_cell.x >>> stage;

    always_comb
    begin
        cell_next.valid = in_cell.valid;
        cell_next.flip  = in_cell.flip;
        if (in_cell.z >= 0)
        begin
            cell_next.x = in_cell.x - dx;
            cell_next.y = in_cell.y + dy;
            cell_next.z = in_cell.z - atan;
        end
        else
        begin
            cell_next.x = in_cell.x + dx;
            cell_next.y = in_cell.y - dy;
            cell_next.z = in_cell.z + atan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg.valid <= 1'b0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign out_cell = cell_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/e2q_quat.sv
// ----------------------------------------------------------------------------
// e2q_quat
// Quaternion products, rounding and saturation, three pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_quat
    import e2q_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cell_t                   cell_x,
    input  wire cell_t                   cell_y,
    input  wire cell_t                   cell_z,
    output logic                         done,
    output logic signed [OUT_W-1:0]      quat_w,
    output logic signed [OUT_W-1:0]      quat_x,
    output logic signed [OUT_W-1:0]      quat_y,
    output logic signed [OUT_W-1:0]      quat_z
);

    localparam int SH  = 2 * QF - OUT_FRAC_BITS;
    localparam int SW  = 2 * PW + 1;
    localparam int RSW = SW - SH;

    logic signed [PW-1:0]   cx, sx, cy, sy, cz, sz;
    logic signed [2*PW-1:0] pr_cc, pr_ss, pr_sc, pr_cs;

    logic                   v1_reg;
    logic signed [PW-1:0]   cc_reg, ss_reg, sc_reg, cs_reg, cz_reg, sz_reg;

    logic                   v2_reg;
    logic signed [2*PW-1:0] t_ccc_reg, t_sss_reg, t_scc_reg, t_css_reg;
    logic signed [2*PW-1:0] t_csc_reg, t_scs_reg, t_ccs_reg, t_ssc_reg;

    logic signed [SW-1:0]   sum_w, sum_x, sum_y, sum_z;
    logic signed [OUT_W-1:0] w_next, x_next, y_next, z_next;
    logic                   done_reg;
    logic signed [OUT_W-1:0] w_reg, x_reg, y_reg, z_reg;

    function automatic logic signed [OUT_W-1:0] finish(input logic signed [SW-1:0] v);
        logic signed [SW-1:0]  rnd;
        logic signed [RSW-1:0] r;
        rnd = v + (SW'(1) <<< (SH - 1));
        r   = RSW'(rnd >>> SH);
        if (r > RSW'(32767))
        begin
            finish = 16'sh7fff;
        end
        else if (r < -RSW'(32768))
        begin
            finish = 16'sh8000;
        end
        else
        begin
            finish = r[OUT_W-1:0];
        end
    endfunction

    // take a half-turn back by negating sine and cosine
    assign cx = cell_x.flip ? -PW'(cell_x.x) : PW'(cell_x.x);
    assign sx = cell_x.flip ? -PW'(cell_x.y) : PW'(cell_x.y);
    assign cy = cell_y.flip ? -PW'(cell_y.x) : PW'(cell_y.x);
    assign sy = cell_y.flip ? -PW'(cell_y.y) : PW'(cell_y.y);
    assign cz = cell_z.flip ? -PW'(cell_z.x) : PW'(cell_z.x);
    assign sz = cell_z.flip ? -PW'(cell_z.y) : PW'(cell_z.y);

    assign pr_cc = 64'(cx) * 64'(cy);
    assign pr_ss = 64'(sx) * 64'(sy);
    assign pr_sc = 64'(sx) * 64'(cy);
    assign pr_cs = 64'(cx) * 64'(sy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= cell_x.valid;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cc_reg <= PW'(pr_cc >>> QF);
        ss_reg <= PW'(pr_ss >>> QF);
        sc_reg <= PW'(pr_sc >>> QF);
        cs_reg <= PW'(pr_cs >>> QF);
        cz_reg <= cz;
        sz_reg <= sz;
    end

    always_ff @(posedge clk)
    begin
        t_ccc_reg <= 64'(cc_reg) * 64'(cz_reg);
        t_sss_reg <= 64'(ss_reg) * 64'(sz_reg);
        t_scc_reg <= 64'(sc_reg) * 64'(cz_reg);
        t_css_reg <= 64'(cs_reg) * 64'(sz_reg);
        t_csc_reg <= 64'(cs_reg) * 64'(cz_reg);
        t_scs_reg <= 64'(sc_reg) * 64'(sz_reg);
        t_ccs_reg <= 64'(cc_reg) * 64'(sz_reg);
        t_ssc_reg <= 64'(ss_reg) * 64'(cz_reg);
    end

    assign sum_w = SW'(t_ccc_reg) - SW'(t_sss_reg);
    assign sum_x = SW'(t_scc_reg) + SW'(t_css_reg);
    assign sum_y = SW'(t_csc_reg) - SW'(t_scs_reg);
    assign sum_z = SW'(t_ccs_reg) + SW'(t_ssc_reg);

    assign w_next = finish(sum_w);
    assign x_next = finish(sum_x);
    assign y_next = finish(sum_y);
    assign z_next = finish(sum_z);

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done   = done_reg;
    assign quat_w = w_reg;
    assign quat_x = x_reg;
    assign quat_y = y_reg;
    assign quat_z = z_reg;

endmodule

`default_nettype wire

FILE: dv/e2q_checker.sv
// ----------------------------------------------------------------------------
// e2q_checker
// Watches the command and result channels of euler_to_quaternion, predicts
// each quaternion from the accepted angles and compares in transfer order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module e2q_checker
    import e2q_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic                    busy,
    input  wire logic signed [IN_W-1:0]  angle_x,
    input  wire logic signed [IN_W-1:0]  angle_y,
    input  wire logic signed [IN_W-1:0]  angle_z,
    input  wire logic                    done,
    input  wire logic signed [OUT_W-1:0] quat_w,
    input  wire logic signed [OUT_W-1:0] quat_x,
    input  wire logic signed [OUT_W-1:0] quat_y,
    input  wire logic signed [OUT_W-1:0] quat_z,
    output int                           errors,
    output int                           pending
);

    typedef struct packed {
        logic signed [OUT_W-1:0] w;
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } quat_t;

    quat_t quat_q[$];

    localparam longint TURN_ATAN [32] = '{
        843314856, 497837829, 263043836, 133525158,
        67021686,  33543515,  16775850,  8388437,
        4194282,   2097149,   1048575,   524287,
        262143,    131071,    65535,     32767,
        16383,     8191,      4095,      2047,
        1023,      511,       255,       127,
        63,        31,        15,        7,
        3,         1,         0,         0
    };

    function automatic void half_sin_cos(input longint a, output longint s,
                                         output longint c);
        longint qtr, per, den, r, mag, z, x, y, dx, dy;
        bit     flip;
        qtr  = longint'(180) << ANGLE_FRAC_BITS;
        per  = 4 * qtr;
        den  = longint'(360) << ANGLE_FRAC_BITS;
        flip = 0;
        r    = a % per;
        if (r < 0)
            r += per;
        if (r > qtr && r <= 3 * qtr)
        begin
            r -= 2 * qtr;
            flip = 1;
        end
        else if (r > 3 * qtr)
            r -= per;
        mag = (r < 0) ? -r : r;
        z   = (mag * 64'sd3373259426 + den / 2) / den;
        if (r < 0)
            z = -z;
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= TURN_ATAN[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += TURN_ATAN[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint prod3(input longint a, input longint b,
                                     input longint c);
        return ((a * b) >>> 30) * c;
    endfunction

    function automatic logic signed [OUT_W-1:0] round_sat(input longint v);
        int     sh;
        longint r;
        sh = 60 - OUT_FRAC_BITS;
        r  = (v + (longint'(1) <<< (sh - 1))) >>> sh;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[OUT_W-1:0];
    endfunction

    function automatic quat_t predict_quat(input longint ax, input longint ay,
                                           input longint az);
        longint sx, cx, sy, cy, sz, cz;
        quat_t  q;
        half_sin_cos(ax, sx, cx);
        half_sin_cos(ay, sy, cy);
        half_sin_cos(az, sz, cz);
        q.w = round_sat(prod3(cx, cy, cz) - prod3(sx, sy, sz));
        q.x = round_sat(prod3(sx, cy, cz) + prod3(cx, sy, sz));
        q.y = round_sat(prod3(cx, sy, cz) - prod3(sx, cy, sz));
        q.z = round_sat(prod3(cx, cy, sz) + prod3(sx, sy, cz));
        return q;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        quat_t e;
        if (rst_n && done)
        begin
            if (quat_q.size() == 0)
                report("unexpected result", 1, 0);
            else
            begin
                e = quat_q.pop_front();
                if (quat_w !== e.w) report("quat_w", quat_w, e.w);
                if (quat_x !== e.x) report("quat_x", quat_x, e.x);
                if (quat_y !== e.y) report("quat_y", quat_y, e.y);
                if (quat_z !== e.z) report("quat_z", quat_z, e.z);
            end
        end
        if (rst_n && start && !busy)
            quat_q.push_back(predict_quat(angle_x, angle_y, angle_z));
        pending = quat_q.size();
    end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives angle triples into euler_to_quaternion: directed extremes, wrap and
// quadrant edges, then random angles with bursts of idle cycles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import e2q_pkg::*;

    localparam int WATCHDOG = 2000;

    logic                    clk = 0;
    logic                    rst_n = 0;
    logic                    start = 0;
    logic signed [IN_W-1:0]  angle_x = '0;
    logic signed [IN_W-1:0]  angle_y = '0;
    logic signed [IN_W-1:0]  angle_z = '0;
    logic                    busy, done;
    logic signed [OUT_W-1:0] quat_w, quat_x, quat_y, quat_z;
    int                      errors, pending;
    int                      quiet = 0;

    always #5 clk = ~clk;

    euler_to_quaternion u_top (.*);

    e2q_checker u_chk (.*);

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send(input int ax, input int ay, input int az);
        angle_x <= ax[IN_W-1:0];
        angle_y <= ay[IN_W-1:0];
        angle_z <= az[IN_W-1:0];
        start   <= 1;
        do @(posedge clk); while (busy);
    endtask

    function automatic int rand_angle();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 131071) - 65536;
            1: return 23040 * ($urandom_range(0, 8) - 4) + $urandom_range(0, 4) - 2;
            default: return $urandom_range(0, 92160) - 46080;
        endcase
    endfunction

    int dir [14] = '{0, 1, -1, 46080, -46080, 23040, -23040, 23041, -23041,
                     65535, -65536, 11520, 34560, 69120};

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        foreach (dir[i])
            send(dir[i], dir[(i + 5) % 14], dir[(i + 9) % 14]);
        send(dir[0], dir[0], dir[3]);
        send(dir[3], dir[3], dir[3]);
        send(dir[4], dir[4], dir[4]);
        send(dir[9], dir[10], dir[9]);
        for (int n = 0; n < 1400; n++)
        begin
            if (n < 1200 && $urandom_range(0, 7) == 0)
            begin
                start <= 0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            send(rand_angle(), rand_angle(), rand_angle());
        end
        start <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/e2q_pkg.sv
hw/rtl/e2q_prep.sv
hw/rtl/e2q_cordic_cell.sv
hw/rtl/e2q_quat.sv
hw/rtl/euler_to_quaternion.sv
dv/e2q_checker.sv
dv/tb_top.sv
